// ===== design/bmp_integer_upscaler_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the integer upscaler checks
// Clock and reset names follow the top-level ports.
// ----------------------------------------------------------------------------
`ifndef BMP_INTEGER_UPSCALER_TOP_ASSERT_SVH
`define BMP_INTEGER_UPSCALER_TOP_ASSERT_SVH

// Same-cycle implication, checked on every clock outside reset.
`define BMP_UPS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bmp_integer_upscaler: check failed");

// Next-cycle implication, checked on every clock outside reset.
`define BMP_UPS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bmp_integer_upscaler: check failed");

`endif

// ===== design/bmp_ups_pkg.sv =====
// ----------------------------------------------------------------------------
// bmp_ups_pkg
// Shared constants, register codes and payload types of the upscaler.
// ----------------------------------------------------------------------------
package bmp_ups_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_SCALE  = 64;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int REP_W      = $clog2(MAX_SCALE);
    localparam int WIDTH_W    = 12;
    localparam int SCALE_W    = 7;
    localparam int HEIGHT_W   = 16;
    localparam int PIX_W      = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCALE     = 2'd0,
        REG_IN_WIDTH  = 2'd1,
        REG_IN_HEIGHT = 2'd2
    } t_cfg_reg;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_REPLAY = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [1:0] pad_bytes;
        logic       row_end;
        logic       frame_end;
        logic       order_error;
        logic       last;
    } t_out_item;

    // Per-request decisions made by the sequencer at accept time
    typedef struct packed {
        logic       replay;
        logic       err;
        logic       row_end;
        logic       frame_end;
        logic [1:0] pad;
    } t_item_ctl;

    typedef struct packed {
        logic             we;
        logic             re;
        logic [COL_W-1:0] addr;
    } t_mem_req;

endpackage

// ===== design/bmp_ups_ctrl.sv =====
// ----------------------------------------------------------------------------
// bmp_ups_ctrl
// Configuration registers and scanline sequencer: tracks column, row copy
// and row count, checks request order and drives the line buffer port.
// ----------------------------------------------------------------------------
module bmp_ups_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [bmp_ups_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bmp_ups_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                                i_accept,
    input  logic                                i_opcode,
    output bmp_ups_pkg::t_item_ctl              o_ctl,
    output bmp_ups_pkg::t_mem_req               o_mem,
    output logic [bmp_ups_pkg::SCALE_W-1:0]     o_scale
);

    localparam int SW = bmp_ups_pkg::SCALE_W;
    localparam int WW = bmp_ups_pkg::WIDTH_W;
    localparam int HW = bmp_ups_pkg::HEIGHT_W;
    localparam int CW = bmp_ups_pkg::COL_W;
    localparam int RW = bmp_ups_pkg::REP_W;

    logic [SW-1:0] r_scale,  n_scale;
    logic [WW-1:0] r_width,  n_width;
    logic [HW-1:0] r_height, n_height;
    logic [CW-1:0] r_column, n_column;
    logic [RW-1:0] r_repeat, n_repeat;
    logic [HW-1:0] r_row,    n_row;
    logic          r_phase,  n_phase;

    logic [SW-1:0] cfg_scale;
    logic [WW-1:0] cfg_width;
    logic [HW-1:0] cfg_height;
    logic [SW-1:0] copies;
    logic          row_end;
    logic          frame_end;
    logic          err;
    logic          rows_done;

    // Saturate register values once at write time
    always_comb begin
        cfg_scale  = i_cfg_data[SW-1:0];
        cfg_width  = i_cfg_data[WW-1:0];
        cfg_height = i_cfg_data[HW-1:0];
        if (cfg_scale == '0) begin
            cfg_scale = SW'(1);
        end else if (cfg_scale > SW'(bmp_ups_pkg::MAX_SCALE)) begin
            cfg_scale = SW'(bmp_ups_pkg::MAX_SCALE);
        end
        if (cfg_width == '0) begin
            cfg_width = WW'(1);
        end else if (cfg_width > WW'(bmp_ups_pkg::MAX_WIDTH)) begin
            cfg_width = WW'(bmp_ups_pkg::MAX_WIDTH);
        end
        if (cfg_height == '0) begin
            cfg_height = HW'(1);
        end
    end

    always_comb begin
        err       = (i_opcode != r_phase);
        row_end   = ((WW'(r_column) + WW'(1)) == r_width);
        copies    = (i_opcode == bmp_ups_pkg::OP_LOAD) ? SW'(1) : (SW'(r_repeat) + SW'(1));
        rows_done = (copies >= r_scale);
        frame_end = row_end && rows_done
                    && (({1'b0, r_row} + (HW+1)'(1)) >= {1'b0, r_height});

        n_scale  = r_scale;
        n_width  = r_width;
        n_height = r_height;
        n_column = r_column;
        n_repeat = r_repeat;
        n_row    = r_row;
        n_phase  = r_phase;

        if (i_accept && !err) begin
            if (row_end) begin
                n_column = '0;
                if (rows_done) begin
                    n_row    = frame_end ? '0 : r_row + HW'(1);
                    n_repeat = '0;
                    n_phase  = bmp_ups_pkg::OP_LOAD;
                end else begin
                    n_repeat = RW'(copies);
                    n_phase  = bmp_ups_pkg::OP_REPLAY;
                end
            end else begin
                n_column = r_column + CW'(1);
            end
        end

        // Any known register write restarts the frame
        if (i_cfg_valid) begin
            case (i_cfg_index)
                bmp_ups_pkg::REG_SCALE: begin
                    n_scale = cfg_scale;
                end
                bmp_ups_pkg::REG_IN_WIDTH: begin
                    n_width = cfg_width;
                end
                bmp_ups_pkg::REG_IN_HEIGHT: begin
                    n_height = cfg_height;
                end
                default: begin
                end
            endcase
            if (i_cfg_index == bmp_ups_pkg::REG_SCALE
                || i_cfg_index == bmp_ups_pkg::REG_IN_WIDTH
                || i_cfg_index == bmp_ups_pkg::REG_IN_HEIGHT) begin
                n_column = '0;
                n_repeat = '0;
                n_row    = '0;
                n_phase  = bmp_ups_pkg::OP_LOAD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale  <= SW'(1);
            r_width  <= WW'(1);
            r_height <= HW'(1);
            r_column <= '0;
            r_repeat <= '0;
            r_row    <= '0;
            r_phase  <= bmp_ups_pkg::OP_LOAD;
        end else begin
            r_scale  <= n_scale;
            r_width  <= n_width;
            r_height <= n_height;
            r_column <= n_column;
            r_repeat <= n_repeat;
            r_row    <= n_row;
            r_phase  <= n_phase;
        end
    end

    always_comb begin
        o_ctl.replay    = (i_opcode == bmp_ups_pkg::OP_REPLAY);
        o_ctl.err       = err;
        o_ctl.row_end   = row_end;
        o_ctl.frame_end = frame_end;
        // Output width mod 4 needs only the low two bits of each factor
        o_ctl.pad       = 2'(r_width[1:0] * r_scale[1:0]);

        o_mem.we   = i_accept && !err && (i_opcode == bmp_ups_pkg::OP_LOAD);
        o_mem.re   = i_accept && !err && (i_opcode == bmp_ups_pkg::OP_REPLAY);
        o_mem.addr = r_column;
    end

    assign o_scale = r_scale;

endmodule

// ===== design/bmp_ups_line_buf.sv =====
// ----------------------------------------------------------------------------
// bmp_ups_line_buf
// One-scanline pixel store: one write or one registered read per cycle.
// ----------------------------------------------------------------------------
module bmp_ups_line_buf (
    input  logic                             i_clk,
    input  bmp_ups_pkg::t_mem_req            i_mem,
    input  logic [bmp_ups_pkg::PIX_W-1:0]    i_wdata,
    output logic [bmp_ups_pkg::PIX_W-1:0]    o_rdata
);

    logic [bmp_ups_pkg::PIX_W-1:0] r_mem [bmp_ups_pkg::MAX_WIDTH];
    logic [bmp_ups_pkg::PIX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_mem.we) begin
            r_mem[i_mem.addr] <= i_wdata;
        end
        if (i_mem.re) begin
            r_rdata <= r_mem[i_mem.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/bmp_ups_emit.sv =====
// ----------------------------------------------------------------------------
// bmp_ups_emit
// Request holding stage and output register: repeats each in-order pixel
// scale times and marks its final copy with row, frame and padding flags.
// ----------------------------------------------------------------------------
module bmp_ups_emit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_load,
    input  bmp_ups_pkg::t_item_ctl             i_ctl,
    input  logic [bmp_ups_pkg::PIX_W-1:0]      i_pix,
    input  logic [bmp_ups_pkg::PIX_W-1:0]      i_rdata,
    input  logic [bmp_ups_pkg::SCALE_W-1:0]    i_scale,
    output logic                               o_ready,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output bmp_ups_pkg::t_out_item             o_out_data
);

    localparam int RW = bmp_ups_pkg::REP_W;
    localparam int PW = bmp_ups_pkg::PIX_W;

    logic                   r_s1_valid;
    bmp_ups_pkg::t_item_ctl r_s1_ctl;
    logic [PW-1:0]          r_s1_pix;

    logic                   r_out_valid;
    bmp_ups_pkg::t_item_ctl r_ctl;
    logic [PW-1:0]          r_pix;
    logic [RW-1:0]          r_left;

    logic fin;
    logic move;

    assign fin     = (r_left == '0);
    // Advance the held request once the output is empty or sends its last copy
    assign move    = r_s1_valid && (!r_out_valid || (i_out_ready && fin));
    assign o_ready = !r_s1_valid || move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_s1_valid <= 1'b1;
            end else if (move) begin
                r_s1_valid <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready && fin) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_s1_ctl <= i_ctl;
            r_s1_pix <= i_pix;
        end
        if (move) begin
            r_ctl  <= r_s1_ctl;
            r_pix  <= r_s1_ctl.replay ? i_rdata : r_s1_pix;
            r_left <= r_s1_ctl.err ? '0 : RW'(i_scale - bmp_ups_pkg::SCALE_W'(1));
        end else if (r_out_valid && i_out_ready && !fin) begin
            r_left <= r_left - RW'(1);
        end
    end

    always_comb begin
        o_out_data             = '0;
        o_out_data.last        = fin;
        o_out_data.order_error = r_ctl.err;
        if (!r_ctl.err) begin
            o_out_data.out_red   = r_pix[7:0];
            o_out_data.out_green = r_pix[15:8];
            o_out_data.out_blue  = r_pix[23:16];
            if (fin && r_ctl.row_end) begin
                o_out_data.pad_bytes = r_ctl.pad;
                o_out_data.row_end   = 1'b1;
                o_out_data.frame_end = r_ctl.frame_end;
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== design/bmp_integer_upscaler_top.sv =====
// ----------------------------------------------------------------------------
// bmp_integer_upscaler_top
// Nearest-neighbor integer upscaler for 24-bit RGB scanlines.
// ----------------------------------------------------------------------------
// Each request yields scale results (a misordered request a single result),
// one per cycle while the output is taken. One further request is accepted
// into a holding stage and moves to the output once the last copy of the
// current one is taken. Load requests write the single-port line buffer and
// replay requests read it, one access per cycle. The line buffer needs no
// clearing after reset, so requests are accepted right away. Configuration
// writes are always ready; any write to a known register restarts the frame.
module bmp_integer_upscaler_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bmp_ups_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bmp_ups_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  bmp_ups_pkg::t_in_item               i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output bmp_ups_pkg::t_out_item              o_out_data
);

    logic                                accept;
    bmp_ups_pkg::t_item_ctl              ctl;
    bmp_ups_pkg::t_mem_req               mem;
    logic [bmp_ups_pkg::SCALE_W-1:0]     scale;
    logic [bmp_ups_pkg::PIX_W-1:0]       pix;
    logic [bmp_ups_pkg::PIX_W-1:0]       rdata;

    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && o_in_ready;
    assign pix         = {i_in_data.blue, i_in_data.green, i_in_data.red};

    bmp_ups_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_opcode    (i_in_data.opcode),
        .o_ctl       (ctl),
        .o_mem       (mem),
        .o_scale     (scale)
    );

    bmp_ups_line_buf u_line_buf (
        .i_clk   (i_clk),
        .i_mem   (mem),
        .i_wdata (pix),
        .o_rdata (rdata)
    );

    bmp_ups_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_ctl       (ctl),
        .i_pix       (pix),
        .i_rdata     (rdata),
        .i_scale     (scale),
        .o_ready     (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== design/bmp_ups_chk.sv =====
// ----------------------------------------------------------------------------
// bmp_ups_chk
// Port-level checks of the upscaler, bound to the top level.
// ----------------------------------------------------------------------------
`include "bmp_integer_upscaler_top_assert.svh"

module bmp_ups_chk (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   o_in_ready,
    input  logic                   o_out_valid,
    input  logic                   i_out_ready,
    input  bmp_ups_pkg::t_out_item o_out_data
);

    // Hold a stalled result
    `BMP_UPS_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))

    // An order error is a single clean result
    `BMP_UPS_ASSERT_IMP(a_err_clean, o_out_valid && o_out_data.order_error, o_out_data.last && !o_out_data.row_end && !o_out_data.frame_end && (o_out_data.pad_bytes == 2'd0))

    // Frame end only on the final copy of a row end
    `BMP_UPS_ASSERT_IMP(a_frame_row, o_out_valid && o_out_data.frame_end, o_out_data.row_end && o_out_data.last)

    // Padding appears only at a row end
    `BMP_UPS_ASSERT_IMP(a_pad_row, o_out_valid && (o_out_data.pad_bytes != 2'd0), o_out_data.row_end)

    // Requests back up only behind a pending result
    `BMP_UPS_ASSERT_IMP(a_stall_cause, !o_in_ready, o_out_valid)

endmodule

bind bmp_integer_upscaler_top bmp_ups_chk u_chk (.*);

// ===== tb/bmp_integer_upscaler_top_test.sv =====
// ----------------------------------------------------------------------------
// bmp_integer_upscaler_top_test
// Self-checking bench for the nearest-neighbor scanline upscaler. A local
// model of the line buffer and row sequencing predicts every output pixel,
// its padding, row and frame flags, and order errors. Directed tests cover
// power-on defaults, misordered requests, register corner values and the
// largest sizes; a random test then runs well-formed frames with noise and
// frame restarts. Both channels idle at random throughout.
// ----------------------------------------------------------------------------
module bmp_integer_upscaler_top_test;

    import bmp_ups_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned RANDOM_ITEMS = 230;
    localparam int unsigned WIDE_ITEMS   = 40;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned MAX_PRINTED  = 40;

    // Register index past the end of the register list
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum int {RX_STEADY, RX_LIGHT, RX_HEAVY, RX_PERIODIC} t_rx_mode;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;
    logic                   i_in_valid  = 1'b0;
    logic                   o_in_ready;
    t_in_item               i_in_data   = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    t_out_item              o_out_data;

    // Model state
    logic [PIX_W-1:0]       line_store [MAX_WIDTH];
    logic [COL_W-1:0]       column       = '0;
    logic [REP_W-1:0]       copies_done  = '0;
    logic [HEIGHT_W-1:0]    row_count    = '0;
    logic                   replay_phase = OP_LOAD;
    logic [SCALE_W-1:0]     scale_reg    = 7'd1;
    logic [WIDTH_W-1:0]     width_reg    = 12'd1;
    logic [HEIGHT_W-1:0]    height_reg   = 16'd1;

    t_out_item              expected_pixels [$];
    int unsigned            error_count  = 0;
    int unsigned            result_count = 0;
    int unsigned            cycle_count  = 0;
    int unsigned            burst_left   = 0;
    t_rx_mode               rx_mode      = RX_STEADY;
    int unsigned            rx_hold      = 0;

    bmp_integer_upscaler_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, expected_pixels.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver stalls: switch between steady, light, heavy and periodic stalls
    always @(posedge i_clk) begin
        if (rx_hold == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_hold = $urandom_range(16, 160);
        end
        rx_hold--;
        case (rx_mode)
            RX_STEADY:   i_out_ready <= 1'b1;
            RX_LIGHT:    i_out_ready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY:    i_out_ready <= ($urandom_range(0, 2) == 0);
            RX_PERIODIC: i_out_ready <= (rx_hold % 3 != 0);
            default:     i_out_ready <= 1'b1;
        endcase
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTED) begin
            $display("mismatch at result %0d: %s", result_count, msg);
        end
    endtask

    // Output pixels a request produces, updating the model state
    task automatic upscale_pixel(input t_in_item req);
        int unsigned      s, w, h, copies;
        logic [PIX_W-1:0] rgb;
        logic             at_row_end;
        logic             at_frame_end;
        logic [1:0]       pad;
        t_out_item        pix;
        s = (scale_reg == 0) ? 1 : (scale_reg > MAX_SCALE) ? MAX_SCALE : scale_reg;
        w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
        h = (height_reg == 0) ? 1 : height_reg;
        pix = '0;
        if (req.opcode != replay_phase) begin
            pix.order_error = 1'b1;
            pix.last        = 1'b1;
            expected_pixels.push_back(pix);
            return;
        end
        at_frame_end = 1'b0;
        if (req.opcode == OP_LOAD) begin
            rgb = {req.red, req.green, req.blue};
            line_store[column] = rgb;
        end else begin
            rgb = line_store[column];
        end
        at_row_end = (column + 1 == w);
        pad = 2'((w * s) & 3);
        if (at_row_end) begin
            copies = (req.opcode == OP_LOAD) ? 1 : copies_done + 1;
            column = '0;
            if (copies >= s) begin
                at_frame_end = (row_count + 1 >= h);
                row_count    = at_frame_end ? '0 : row_count + 1'b1;
                copies_done  = '0;
                replay_phase = OP_LOAD;
            end else begin
                copies_done  = REP_W'(copies);
                replay_phase = OP_REPLAY;
            end
        end else begin
            column = column + 1'b1;
        end
        for (int k = 0; k < s; k++) begin
            pix.out_red   = rgb[23:16];
            pix.out_green = rgb[15:8];
            pix.out_blue  = rgb[7:0];
            pix.pad_bytes = (k == s - 1 && at_row_end) ? pad : 2'd0;
            pix.row_end   = (k == s - 1) && at_row_end;
            pix.frame_end = (k == s - 1) && at_frame_end;
            pix.last      = (k == s - 1);
            expected_pixels.push_back(pix);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", o_out_data));
            end else begin
                want = expected_pixels.pop_front();
                if (o_out_data.out_red !== want.out_red)
                    report_mismatch($sformatf("out_red %h, want %h",
                                              o_out_data.out_red, want.out_red));
                if (o_out_data.out_green !== want.out_green)
                    report_mismatch($sformatf("out_green %h, want %h",
                                              o_out_data.out_green, want.out_green));
                if (o_out_data.out_blue !== want.out_blue)
                    report_mismatch($sformatf("out_blue %h, want %h",
                                              o_out_data.out_blue, want.out_blue));
                if (o_out_data.pad_bytes !== want.pad_bytes)
                    report_mismatch($sformatf("pad_bytes %0d, want %0d",
                                              o_out_data.pad_bytes, want.pad_bytes));
                if (o_out_data.row_end !== want.row_end)
                    report_mismatch($sformatf("row_end %b, want %b",
                                              o_out_data.row_end, want.row_end));
                if (o_out_data.frame_end !== want.frame_end)
                    report_mismatch($sformatf("frame_end %b, want %b",
                                              o_out_data.frame_end, want.frame_end));
                if (o_out_data.order_error !== want.order_error)
                    report_mismatch($sformatf("order_error %b, want %b",
                                              o_out_data.order_error, want.order_error));
                if (o_out_data.last !== want.last)
                    report_mismatch($sformatf("last %b, want %b",
                                              o_out_data.last, want.last));
            end
            result_count++;
        end
    end

    function automatic t_in_item make_item(input logic op, input logic [PIX_W-1:0] rgb);
        return t_in_item'({op, rgb});
    endfunction

    // Send one request; valid stays high into the next request within a burst
    task automatic send_item(input t_in_item req);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (!o_in_ready);
        upscale_pixel(req);
    endtask

    // Drop the request valid and wait until every predicted pixel has arrived
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_SCALE:     scale_reg  = data[SCALE_W-1:0];
            REG_IN_WIDTH:  width_reg  = data[WIDTH_W-1:0];
            REG_IN_HEIGHT: height_reg = data[HEIGHT_W-1:0];
            default: ;
        endcase
        // Any known register restarts the frame; the line buffer is kept
        if (idx != REG_UNUSED) begin
            column       = '0;
            copies_done  = '0;
            row_count    = '0;
            replay_phase = OP_LOAD;
        end
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] scale_data,
                             input logic [CFG_DATA_W-1:0] width_data,
                             input logic [CFG_DATA_W-1:0] height_data);
        drain_results();
        cfg_write(REG_SCALE, scale_data);
        cfg_write(REG_IN_WIDTH, width_data);
        cfg_write(REG_IN_HEIGHT, height_data);
        i_cfg_valid <= 1'b0;
    endtask

    // Reset values: scale 1, one pixel per row, one row per frame
    task automatic test_power_on_defaults();
        send_item(make_item(OP_LOAD, 24'h000000));
        send_item(make_item(OP_LOAD, 24'hFFFFFF));
        send_item(make_item(OP_REPLAY, 24'hFFFFFF));
    endtask

    task automatic test_phase_errors();
        configure(16'd2, 16'd2, 16'd2);
        send_item(make_item(OP_REPLAY, 24'hA5A5A5));
        send_item(make_item(OP_LOAD, 24'h00FF00));
        send_item(make_item(OP_LOAD, 24'hFF00FF));
        send_item(make_item(OP_LOAD, 24'h5A5A5A));
        send_item(make_item(OP_REPLAY, 24'h000000));
        send_item(make_item(OP_REPLAY, 24'hFFFFFF));
        send_item(make_item(OP_LOAD, 24'h123456));
        send_item(make_item(OP_LOAD, 24'hEDCBA9));
        send_item(make_item(OP_REPLAY, 24'h0F0F0F));
        send_item(make_item(OP_REPLAY, 24'hF0F0F0));
        // frame has wrapped, so a replay is out of order again
        send_item(make_item(OP_REPLAY, 24'h3C3C3C));
    endtask

    task automatic test_register_corners();
        // zero values act as one
        configure(16'h0000, 16'h0000, 16'h0000);
        send_item(make_item(OP_LOAD, 24'h800001));
        send_item(make_item(OP_LOAD, 24'h7FFFFE));
        // bits above each register width are dropped
        configure(16'hFF83, 16'hF003, 16'h0001);
        send_item(make_item(OP_LOAD, 24'h111111));
        send_item(make_item(OP_LOAD, 24'h222222));
        // unknown index mid-row leaves the frame position alone
        drain_results();
        cfg_write(REG_UNUSED, 16'hFFFF);
        i_cfg_valid <= 1'b0;
        send_item(make_item(OP_LOAD, 24'h333333));
        repeat (6) send_item(make_item(OP_REPLAY, PIX_W'($urandom)));
    endtask

    task automatic test_largest_sizes();
        // scale saturates to the maximum, one row of one pixel
        configure(16'hFFFF, 16'h0001, 16'h0001);
        for (int k = 0; k < MAX_SCALE; k++) begin
            send_item(make_item((k == 0) ? OP_LOAD : OP_REPLAY, PIX_W'($urandom)));
        end
        // width saturates to the line buffer size: no row end early in the row
        configure(16'h0001, 16'hFFFF, 16'hFFFF);
        for (int k = 0; k < WIDE_ITEMS; k++) begin
            send_item(make_item(OP_LOAD, PIX_W'($urandom)));
        end
    endtask

    // Sessions of well-formed frames with random content, some misordered
    // requests, and a restart wherever a session stops
    task automatic test_random_frames();
        int unsigned           sent;
        int unsigned           run_len;
        int unsigned           pick;
        logic [CFG_DATA_W-1:0] sd, wd, hd;
        logic                  op;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            sd = CFG_DATA_W'($urandom);
            if (pick < 70)      sd[SCALE_W-1:0] = SCALE_W'($urandom_range(1, 4));
            else if (pick < 90) sd[SCALE_W-1:0] = SCALE_W'($urandom_range(5, 12));
            else if (pick < 95) sd[SCALE_W-1:0] = '0;
            else sd[SCALE_W-1:0] = SCALE_W'($urandom_range(MAX_SCALE + 1, 127));
            pick = $urandom_range(0, 99);
            wd = CFG_DATA_W'($urandom);
            if (pick < 70)      wd[WIDTH_W-1:0] = WIDTH_W'($urandom_range(1, 6));
            else if (pick < 90) wd[WIDTH_W-1:0] = WIDTH_W'($urandom_range(7, 40));
            else if (pick < 95) wd[WIDTH_W-1:0] = '0;
            else wd[WIDTH_W-1:0] = WIDTH_W'($urandom_range(MAX_WIDTH + 1, 4095));
            pick = $urandom_range(0, 99);
            if (pick < 60)      hd = CFG_DATA_W'($urandom_range(1, 3));
            else if (pick < 80) hd = '0;
            else                hd = CFG_DATA_W'($urandom);
            if ($urandom_range(0, 3) == 0) begin
                drain_results();
                cfg_write(REG_UNUSED, CFG_DATA_W'($urandom));
            end
            configure(sd, wd, hd);
            run_len = $urandom_range(8, 60);
            repeat (run_len) begin
                op = replay_phase;
                if ($urandom_range(0, 11) == 0) op = ~op;
                send_item(make_item(op, PIX_W'($urandom)));
            end
            sent += run_len;
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_power_on_defaults();
        test_phase_errors();
        test_register_corners();
        test_largest_sizes();
        test_random_frames();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== bmp_integer_upscaler_top.f =====
+incdir+design
design/bmp_ups_pkg.sv
design/bmp_ups_ctrl.sv
design/bmp_ups_line_buf.sv
design/bmp_ups_emit.sv
design/bmp_integer_upscaler_top.sv
design/bmp_ups_chk.sv
tb/bmp_integer_upscaler_top_test.sv
